// ===== hdl/hashed_page_table_engine_top_assert.svh =====
// Assertion macros shared by the engine RTL
`ifndef HASHED_PAGE_TABLE_ENGINE_TOP_ASSERT_SVH
`define HASHED_PAGE_TABLE_ENGINE_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define HPTE_AST_IMP(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (b)) \
        else $error("assertion failed");
`define HPTE_AST_NXT(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define HPTE_AST_IMP(lbl, clk, rstn, a, b)
`define HPTE_AST_NXT(lbl, clk, rstn, a, b)
`endif
`endif

// ===== hdl/hpte_pkg.sv =====
`default_nettype none
package hpte_pkg;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_PURGE  = 2'd2;

    localparam logic [2:0] ST_UPDATED  = 3'd0;
    localparam logic [2:0] ST_PLACED   = 3'd1;
    localparam logic [2:0] ST_EVICTED  = 3'd2;
    localparam logic [2:0] ST_REMOVED  = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;
    localparam logic [2:0] ST_PURGED   = 3'd5;

    localparam logic [1:0] FK_NONE = 2'd0;
    localparam logic [1:0] FK_PAGE = 2'd1;
    localparam logic [1:0] FK_ALL  = 2'd2;

    localparam logic [31:0] M_HSEL     = 32'h0000_0040;
    localparam logic [23:0] KVSID_BASE = 24'hFF_FFF0;
    localparam logic [13:0] COUNT_MAX  = 14'h3FFF;

    typedef enum logic [2:0] {
        RS_NONE, RS_MATCH, RS_FREE, RS_EVICT, RS_NOTFOUND, RS_PURGED, RS_BAD
    } res_sel_t;

    typedef struct packed {
        logic     rd_grp;
        logic     grp_sec;
        logic     rd_row;
        logic     purge_wr;
        logic     clear_wr;
        logic     row_inc;
        logic     load_out;
        res_sel_t res_sel;
    } ctrl_cmd_t;

    typedef struct packed {
        logic hit;
        logic free;
        logic is_insert;
        logic row_last;
        logic out_free;
    } dp_stat_t;

    typedef struct packed {
        logic [13:0] cnt;
        logic [31:0] fa;
        logic [1:0]  fk;
        logic [2:0]  slot;
        logic        sec;
        logic [2:0]  status;
    } result_t;

    function automatic logic [11:0] real_flags(input logic [3:0] fl);
        logic [11:0] r;
        r = 12'h190;
        if (fl[3]) r = r | 12'h028;
        if (fl[2]) r = r | 12'h040;
        if (fl[1]) r = r | (fl[0] ? 12'h002 : 12'h003);
        else       r = r | (fl[0] ? 12'h000 : 12'h003);
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/hpte_ctrl.sv =====
`default_nettype none
`include "hashed_page_table_engine_top_assert.svh"
module hpte_ctrl (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     s_tvalid,
    input  wire  [1:0]              s_cmd,
    output logic                    s_tready,
    input  wire  hpte_pkg::dp_stat_t stat,
    output hpte_pkg::ctrl_cmd_t     cmd
);

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_LOOK0 = 9'b000000100,
        S_CHK0  = 9'b000001000,
        S_LOOK1 = 9'b000010000,
        S_CHK1  = 9'b000100000,
        S_PREAD = 9'b001000000,
        S_PWR   = 9'b010000000,
        S_EMIT  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_sel = hpte_pkg::RS_NONE;
        s_tready   = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clear_wr = 1'b1;
                cmd.row_inc  = 1'b1;
                if (stat.row_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    case (s_cmd)
                        hpte_pkg::CMD_INSERT: state_next = S_LOOK0;
                        hpte_pkg::CMD_REMOVE: state_next = S_LOOK0;
                        hpte_pkg::CMD_PURGE:  state_next = S_PREAD;
                        default: begin
                            cmd.res_sel = hpte_pkg::RS_BAD;
                            state_next  = S_EMIT;
                        end
                    endcase
                end
            end
            S_LOOK0: begin
                cmd.rd_grp = 1'b1;
                state_next = S_CHK0;
            end
            S_CHK0: begin
                if (stat.hit) begin
                    cmd.res_sel = hpte_pkg::RS_MATCH;
                    state_next  = S_EMIT;
                end else if (stat.is_insert && stat.free) begin
                    cmd.res_sel = hpte_pkg::RS_FREE;
                    state_next  = S_EMIT;
                end else begin
                    state_next = S_LOOK1;
                end
            end
            S_LOOK1: begin
                cmd.rd_grp  = 1'b1;
                cmd.grp_sec = 1'b1;
                state_next  = S_CHK1;
            end
            S_CHK1: begin
                cmd.grp_sec = 1'b1;
                state_next  = S_EMIT;
                if (stat.hit)                       cmd.res_sel = hpte_pkg::RS_MATCH;
                else if (stat.is_insert && stat.free) cmd.res_sel = hpte_pkg::RS_FREE;
                else if (stat.is_insert)            cmd.res_sel = hpte_pkg::RS_EVICT;
                else                                cmd.res_sel = hpte_pkg::RS_NOTFOUND;
            end
            S_PREAD: begin
                cmd.rd_row = 1'b1;
                state_next = S_PWR;
            end
            S_PWR: begin
                cmd.purge_wr = 1'b1;
                cmd.row_inc  = 1'b1;
                if (stat.row_last) begin
                    cmd.res_sel = hpte_pkg::RS_PURGED;
                    state_next  = S_EMIT;
                end else begin
                    state_next = S_PREAD;
                end
            end
            S_EMIT: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    `HPTE_AST_NXT(a_purge_end, aclk, aresetn, state_reg == S_PWR && stat.row_last,
        state_reg == S_EMIT)
    `HPTE_AST_NXT(a_look_chk, aclk, aresetn, state_reg == S_LOOK1, state_reg == S_CHK1)
    `HPTE_AST_IMP(a_ready_idle, aclk, aresetn, s_tready, state_reg == S_IDLE)

endmodule
`default_nettype wire

// ===== hdl/hpte_dp.sv =====
`default_nettype none
`include "hashed_page_table_engine_top_assert.svh"
module hpte_dp #(
    parameter int GROUP_INDEX_BITS = 10
) (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       load_in,
    input  wire  [79:0]               s_tdata,
    input  hpte_pkg::ctrl_cmd_t       cmd,
    output hpte_pkg::dp_stat_t        stat,
    output logic                      m_tvalid,
    input  wire                       m_tready,
    output logic [55:0]               m_tdata
);

    localparam int G  = GROUP_INDEX_BITS;
    localparam int NG = 1 << G;

    logic [63:0] mem [0:NG-1][0:7];

    logic [1:0]  cmd_reg;
    logic [14:0] ctx_reg;
    logic [31:0] va_reg;
    logic [19:0] pp_reg;
    logic [3:0]  fl_reg;
    logic [G-1:0] row_reg;
    logic [13:0] cnt_reg, cnt_next;
    logic [2:0]  victim_reg;
    logic [63:0] rd_reg [0:7];
    hpte_pkg::result_t res_reg, res_next, out_reg;
    logic        m_valid_reg;

    logic [3:0]  seg;
    logic [23:0] vsid;
    logic [18:0] hash;
    logic [31:0] mw0, want;
    logic [31:0] rw;
    logic [G-1:0] pri_idx, sec_idx, raddr, waddr;
    logic [7:0]  hit, free, pmask, we;
    logic [2:0]  hit_slot, free_slot;
    logic [3:0]  pcnt;
    logic [14:0] csum;
    logic [63:0] wdata;
    logic        re;

    always_comb begin
        seg  = va_reg[31:28];
        vsid = (seg >= 4'd12) ? hpte_pkg::KVSID_BASE + {20'd0, seg - 4'd12}
                              : {5'd0, ctx_reg, seg};
        hash = vsid[18:0] ^ {3'd0, va_reg[27:12]};
        mw0  = {1'b1, vsid, 1'b0, va_reg[27:22]};
        want = cmd.grp_sec ? (mw0 | hpte_pkg::M_HSEL) : mw0;
        rw   = {pp_reg, hpte_pkg::real_flags(fl_reg)};
        pri_idx = hash[G-1:0];
        sec_idx = ~hash[G-1:0];
    end

    always_comb begin
        hit_slot  = 3'd0;
        free_slot = 3'd0;
        pcnt      = 4'd0;
        for (int e = 0; e < 8; e++) begin
            hit[e]   = rd_reg[e][63:32] == want;
            free[e]  = !rd_reg[e][63];
            pmask[e] = rd_reg[e][63] && (rd_reg[e][62:43] == {5'd0, ctx_reg});
            pcnt     = pcnt + {3'd0, pmask[e]};
        end
        for (int e = 7; e >= 0; e--) begin
            if (hit[e])  hit_slot  = 3'(e);
            if (free[e]) free_slot = 3'(e);
        end
        csum     = {1'b0, cnt_reg} + {11'd0, pcnt};
        cnt_next = (csum > {1'b0, hpte_pkg::COUNT_MAX}) ? hpte_pkg::COUNT_MAX : csum[13:0];
    end

    always_comb begin
        stat.hit       = |hit;
        stat.free      = |free;
        stat.is_insert = cmd_reg == hpte_pkg::CMD_INSERT;
        stat.row_last  = &row_reg;
        stat.out_free  = !m_valid_reg || m_tready;
    end

    always_comb begin
        re    = cmd.rd_grp || cmd.rd_row;
        raddr = cmd.rd_row ? row_reg : (cmd.grp_sec ? sec_idx : pri_idx);
        waddr = cmd.grp_sec ? sec_idx : pri_idx;
        we    = 8'd0;
        wdata = {want, rw};
        res_next = res_reg;
        case (cmd.res_sel)
            hpte_pkg::RS_MATCH: begin
                we[hit_slot] = 1'b1;
                if (cmd_reg != hpte_pkg::CMD_INSERT) wdata = 64'd0;
                res_next = '0;
                res_next.status = (cmd_reg == hpte_pkg::CMD_INSERT) ?
                                  hpte_pkg::ST_UPDATED : hpte_pkg::ST_REMOVED;
                res_next.sec  = cmd.grp_sec;
                res_next.slot = hit_slot;
                res_next.fk   = hpte_pkg::FK_PAGE;
                res_next.fa   = {va_reg[31:12], 12'd0};
            end
            hpte_pkg::RS_FREE: begin
                we[free_slot] = 1'b1;
                res_next = '0;
                res_next.status = hpte_pkg::ST_PLACED;
                res_next.sec  = cmd.grp_sec;
                res_next.slot = free_slot;
            end
            hpte_pkg::RS_EVICT: begin
                we[victim_reg] = 1'b1;
                waddr = pri_idx;
                wdata = {mw0, rw};
                res_next = '0;
                res_next.status = hpte_pkg::ST_EVICTED;
                res_next.slot = victim_reg;
                res_next.fk   = hpte_pkg::FK_ALL;
            end
            hpte_pkg::RS_NOTFOUND: begin
                res_next = '0;
                res_next.status = hpte_pkg::ST_NOTFOUND;
                res_next.fk = hpte_pkg::FK_PAGE;
                res_next.fa = {va_reg[31:12], 12'd0};
            end
            hpte_pkg::RS_PURGED: begin
                res_next = '0;
                res_next.status = hpte_pkg::ST_PURGED;
                res_next.fk  = hpte_pkg::FK_ALL;
                res_next.cnt = cnt_next;
            end
            hpte_pkg::RS_BAD: begin
                res_next = '0;
                res_next.status = hpte_pkg::ST_NOTFOUND;
            end
            default: res_next = res_reg;
        endcase
        if (cmd.purge_wr) begin
            waddr = row_reg;
            we    = pmask;
            wdata = 64'd0;
        end
        if (cmd.clear_wr) begin
            waddr = row_reg;
            we    = 8'hFF;
            wdata = 64'd0;
        end
    end

    always_ff @(posedge aclk) begin
        for (int e = 0; e < 8; e++) begin
            if (we[e]) mem[waddr][e] <= wdata;
        end
        if (re) begin
            for (int e = 0; e < 8; e++) rd_reg[e] <= mem[raddr][e];
        end
    end

    always_ff @(posedge aclk) begin
        if (load_in) begin
            cmd_reg <= s_tdata[1:0];
            ctx_reg <= s_tdata[16:2];
            va_reg  <= s_tdata[48:17];
            pp_reg  <= s_tdata[68:49];
            fl_reg  <= s_tdata[72:69];
        end
        res_reg <= res_next;
        if (cmd.load_out) out_reg <= res_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg     <= '0;
            cnt_reg     <= '0;
            victim_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load_in) begin
                row_reg <= '0;
                cnt_reg <= '0;
            end else begin
                if (cmd.row_inc) row_reg <= row_reg + 1'b1;
                if (cmd.purge_wr) cnt_reg <= cnt_next;
            end
            if (cmd.res_sel == hpte_pkg::RS_EVICT) victim_reg <= victim_reg + 3'd1;
            if (cmd.load_out)               m_valid_reg <= 1'b1;
            else if (m_tready)              m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, out_reg};

    `HPTE_AST_IMP(a_match_hit, aclk, aresetn, cmd.res_sel == hpte_pkg::RS_MATCH, |hit)
    `HPTE_AST_IMP(a_free_ok, aclk, aresetn, cmd.res_sel == hpte_pkg::RS_FREE, |free)
    `HPTE_AST_IMP(a_out_free, aclk, aresetn, cmd.load_out, !m_valid_reg || m_tready)

endmodule
`default_nettype wire

// ===== hdl/hashed_page_table_engine_top.sv =====
`default_nettype none
// Insert/remove: one or two group reads (primary, then secondary) from accept to result.
// Purge: each of the 2^GROUP_INDEX_BITS group rows is read, then written back; one item at a time.
// Throughput set by the controller, which accepts a new command only when idle.
// Reset: aresetn synchronous, active low; then a clearing pass over all 2^GROUP_INDEX_BITS
// group rows zeroes the table, s_tready low until it ends.
module hashed_page_table_engine_top #(
    parameter int GROUP_INDEX_BITS = 10
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [79:0] s_tdata,  // cmd, context_req, virt_addr, phys_page, page_flags
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [55:0] m_tdata   // status, in_secondary, slot, flush_kind, flush_addr,
                                  // purged_count
);

    hpte_pkg::ctrl_cmd_t cmd;
    hpte_pkg::dp_stat_t  stat;

    hpte_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_cmd    (s_tdata[1:0]),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    hpte_dp #(.GROUP_INDEX_BITS(GROUP_INDEX_BITS)) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load_in  (s_tvalid && s_tready),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
`default_nettype wire
